/* rtl/bdl_pkg.sv */
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared widths, reset values, register indexes and types for the
// binarize / 2x2 dilation unit.
// ----------------------------------------------------------------------------
package bdl_pkg;

  localparam int PIX_W         = 8;
  localparam int ROW_W         = 12;
  localparam int OUT_COL_W     = 5;
  localparam int HGT_W         = 13;
  localparam int WID_W         = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd127;
  localparam logic [PIX_W-1:0] PIX_ON       = 8'd255;
  localparam logic [PIX_W-1:0] PIX_OFF      = 8'd0;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd20;
  localparam logic [HGT_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [WID_W-1:0] WIDTH_RESET  = 6'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2
  } cfg_reg_t;

  // Classified request handed from front to back (column travels alongside).
  typedef struct packed {
    logic             pix_bit;
    logic             bank;
    logic             last_col;
    logic             last_row;
    logic [ROW_W-1:0] row;
  } bdl_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CALC,
    B_EMIT,
    B_FLUSH
  } back_state_t;

endpackage

/* rtl/bdl_ram.sv */
// ----------------------------------------------------------------------------
// bdl_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bdl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* rtl/bdl_queue.sv */
// ----------------------------------------------------------------------------
// bdl_queue
// Short FIFO between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
module bdl_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/bdl_front.sv */
// ----------------------------------------------------------------------------
// bdl_front
// Config registers, thresholding and raster position tracking. Each pixel
// is classified (position, bank, end of row / frame) and pushed to the queue.
// ----------------------------------------------------------------------------
module bdl_front #(
  parameter int MAX_WIDTH = bdl_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bdl_pkg::PIX_W-1:0]        in_pixel,
  output logic                             q_wr_valid,
  input  logic                             q_wr_ready,
  output logic [$bits(bdl_pkg::bdl_item_t)+$clog2(MAX_WIDTH)-1:0] q_wr_data
);

  import bdl_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] thresh_r;
  logic [HGT_W-1:0] frame_height_r;
  logic [WID_W-1:0] frame_width_r;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic             bank_r, bank_nxt;

  logic [ROW_W-1:0] h_last, row_cur;
  logic [COL_W-1:0] w_last, col_cur;
  logic             accept;
  bdl_item_t        item;

  assign in_ready   = q_wr_ready;
  assign q_wr_valid = in_valid;
  assign accept     = in_valid && q_wr_ready;
  assign q_wr_data  = {item, col_cur};

  always_comb begin
    if (frame_height_r == '0) begin
      h_last = '0;
    end else if (frame_height_r > MAX_HEIGHT) begin
      h_last = ROW_W'(MAX_HEIGHT - HGT_W'(1));
    end else begin
      h_last = ROW_W'(frame_height_r - HGT_W'(1));
    end
    if (frame_width_r == '0) begin
      w_last = '0;
    end else if (frame_width_r > WID_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(frame_width_r - WID_W'(1));
    end
    row_cur = (row_count_r > h_last) ? h_last : row_count_r;
    col_cur = (col_count_r > w_last) ? w_last : col_count_r;

    item.pix_bit  = (in_pixel >= thresh_r);
    item.bank     = bank_r;
    item.last_col = (col_cur == w_last);
    item.last_row = (row_cur == h_last);
    item.row      = row_cur;

    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    bank_nxt      = bank_r;
    if (accept) begin
      if (item.last_col) begin
        col_count_nxt = '0;
        bank_nxt      = !bank_r;
        row_count_nxt = item.last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_count_nxt = col_cur + COL_W'(1);
        row_count_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r       <= THRESH_RESET;
      frame_height_r <= HEIGHT_RESET;
      frame_width_r  <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    thresh_r       <= cfg_wdata[PIX_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[HGT_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[WID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
      bank_r      <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      bank_r      <= bank_nxt;
    end
  end

endmodule

/* rtl/bdl_back.sv */
// ----------------------------------------------------------------------------
// bdl_back
// Sequencer over the two-bank row store: writes the new bit, reads the row
// above, forms the dilated and edge results and flushes the final row.
// ----------------------------------------------------------------------------
module bdl_back #(
  parameter int MAX_WIDTH = bdl_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             q_rd_valid,
  output logic                             q_rd_pop,
  input  logic [$bits(bdl_pkg::bdl_item_t)+$clog2(MAX_WIDTH)-1:0] q_rd_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bdl_pkg::PIX_W-1:0]        out_pixel,
  output logic [bdl_pkg::ROW_W-1:0]        out_row,
  output logic [bdl_pkg::OUT_COL_W-1:0]    out_col,
  output logic                             out_last_in_run
);

  import bdl_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ITEM_W = $bits(bdl_item_t);
  localparam int ADDR_W = $clog2(2 * MAX_WIDTH);

  function automatic logic [ADDR_W-1:0] ram_addr(input logic bank,
                                                 input logic [COL_W-1:0] col);
    ram_addr = bank ? ADDR_W'(MAX_WIDTH) + ADDR_W'(col) : ADDR_W'(col);
  endfunction

  back_state_t      state_r, state_nxt;
  bdl_item_t        item_r, item_nxt, head_item;
  logic [COL_W-1:0] col_r, col_nxt, head_col;
  logic [COL_W-1:0] k_r, k_nxt;
  logic             prvc_r, prvc_nxt;
  logic             dil_val_r, dil_val_nxt;
  logic             cur_cm1_r, cur_cm1_nxt;
  logic             prv_cm1_r, prv_cm1_nxt;
  logic             cache_ok_r, cache_ok_nxt;
  logic             dil_pend_r, dil_pend_nxt;
  logic             edge_pend_r, edge_pend_nxt;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic              out_last_r;

  logic              we, wdata, rd_a, rd_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;

  logic              out_free, emit, emit_bit, emit_last;
  logic [ROW_W-1:0]  emit_row;
  logic [COL_W-1:0]  emit_col;
  logic              has_prev, flush, need_fix;

  assign head_item = q_rd_data[COL_W +: ITEM_W];
  assign head_col  = q_rd_data[COL_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign has_prev  = (item_r.row != '0);
  assign flush     = item_r.last_col && item_r.last_row;
  assign need_fix  = (head_item.row != '0) && (head_col != '0) && !cache_ok_r;

  bdl_ram #(
    .WIDTH (1),
    .DEPTH (2 * MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    prvc_nxt      = prvc_r;
    dil_val_nxt   = dil_val_r;
    cur_cm1_nxt   = cur_cm1_r;
    prv_cm1_nxt   = prv_cm1_r;
    cache_ok_nxt  = cache_ok_r;
    dil_pend_nxt  = dil_pend_r;
    edge_pend_nxt = edge_pend_r;
    q_rd_pop      = 1'b0;
    we            = 1'b0;
    waddr         = ram_addr(item_r.bank, col_r);
    wdata         = item_r.pix_bit;
    raddr_a       = ram_addr(item_r.bank, '0);
    raddr_b       = ram_addr(!item_r.bank, col_r - COL_W'(1));
    emit          = 1'b0;
    emit_bit      = 1'b0;
    emit_row      = item_r.row - ROW_W'(1);
    emit_col      = col_r;
    emit_last     = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_rd_valid) begin
          q_rd_pop = 1'b1;
          item_nxt = head_item;
          col_nxt  = head_col;
          if (need_fix) begin
            // neighbor cache lost after a register write: reload column c-1
            raddr_a   = ram_addr(head_item.bank, head_col - COL_W'(1));
            raddr_b   = ram_addr(!head_item.bank, head_col - COL_W'(1));
            state_nxt = B_READ;
          end else begin
            we        = 1'b1;
            waddr     = ram_addr(head_item.bank, head_col);
            wdata     = head_item.pix_bit;
            raddr_a   = ram_addr(!head_item.bank, head_col);
            state_nxt = B_CALC;
          end
        end
      end
      B_READ: begin
        cur_cm1_nxt = rd_a;
        prv_cm1_nxt = rd_b;
        we          = 1'b1;
        raddr_a     = ram_addr(!item_r.bank, col_r);
        state_nxt   = B_CALC;
      end
      B_CALC: begin
        prvc_nxt      = rd_a;
        dil_val_nxt   = prv_cm1_r | rd_a | cur_cm1_r | item_r.pix_bit;
        dil_pend_nxt  = has_prev && (col_r != '0);
        edge_pend_nxt = has_prev && item_r.last_col;
        cur_cm1_nxt   = item_r.pix_bit;
        prv_cm1_nxt   = rd_a;
        cache_ok_nxt  = 1'b1;
        k_nxt         = '0;
        if ((has_prev && (col_r != '0)) || (has_prev && item_r.last_col)) begin
          state_nxt = B_EMIT;
        end else if (flush) begin
          state_nxt = B_FLUSH;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (dil_pend_r) begin
            emit_bit     = dil_val_r;
            emit_col     = col_r - COL_W'(1);
            emit_last    = !edge_pend_r && !flush;
            dil_pend_nxt = 1'b0;
          end else begin
            emit_bit      = prvc_r;
            emit_last     = !flush;
            edge_pend_nxt = 1'b0;
          end
          if (!(dil_pend_r && edge_pend_r)) begin
            state_nxt = flush ? B_FLUSH : B_IDLE;
          end
        end
      end
      B_FLUSH: begin
        raddr_a = ram_addr(item_r.bank, k_r);
        if (out_free) begin
          emit      = 1'b1;
          emit_bit  = rd_a;
          emit_row  = item_r.row;
          emit_col  = k_r;
          emit_last = (k_r == col_r);
          if (k_r == col_r) begin
            state_nxt = B_IDLE;
          end else begin
            k_nxt   = k_r + COL_W'(1);
            raddr_a = ram_addr(item_r.bank, k_r + COL_W'(1));
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    if (cfg_we) begin
      cache_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cache_ok_r  <= 1'b0;
      dil_pend_r  <= 1'b0;
      edge_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cache_ok_r  <= cache_ok_nxt;
      dil_pend_r  <= dil_pend_nxt;
      edge_pend_r <= edge_pend_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    col_r     <= col_nxt;
    k_r       <= k_nxt;
    prvc_r    <= prvc_nxt;
    dil_val_r <= dil_val_nxt;
    cur_cm1_r <= cur_cm1_nxt;
    prv_cm1_r <= prv_cm1_nxt;
    if (emit) begin
      out_pixel_r <= emit_bit ? PIX_ON : PIX_OFF;
      out_row_r   <= emit_row;
      out_col_r   <= OUT_COL_W'(emit_col);
      out_last_r  <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_in_run = out_last_r;

  a_pixel_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pixel_r == PIX_ON || out_pixel_r == PIX_OFF))
    else $error("result pixel not binary");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FLUSH) |-> (k_r <= col_r))
    else $error("flush column past end of row");

  a_cache_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !cache_ok_r)
    else $error("neighbor cache kept across register write");

endmodule

/* rtl/binarize_dilate_2x2_unit.sv */
// ----------------------------------------------------------------------------
// binarize_dilate_2x2_unit
// Thresholds a raster pixel stream to 0/255 and applies a 2x2 dilation,
// emitting each row one row late and flushing the last row at frame end.
// ----------------------------------------------------------------------------
// Rate: the front accepts a pixel per cycle into a two-entry queue while it
// has room; the back sequencer, bound by the single row store and its
// registered read, pops a pixel only in B_IDLE, after B_CALC and any results
// (n = 1 or 2, in B_EMIT) of the last one. The final pixel of a frame also
// runs the last-row flush, one result per column. A first pixel after a
// register write that lands mid-row below row 0 reloads its left neighbors
// in B_READ. A waiting output register stalls only the emitting states.
// ----------------------------------------------------------------------------
module binarize_dilate_2x2_unit #(
  parameter int MAX_WIDTH = bdl_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bdl_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bdl_pkg::PIX_W-1:0]      out_pixel,
  output logic [bdl_pkg::ROW_W-1:0]      out_row,
  output logic [bdl_pkg::OUT_COL_W-1:0]  out_col,
  output logic                           out_last_in_run
);

  import bdl_pkg::*;

  localparam int Q_W = $bits(bdl_item_t) + $clog2(MAX_WIDTH);

  logic           q_wr_valid, q_wr_ready, q_rd_valid, q_rd_pop;
  logic [Q_W-1:0] q_wr_data, q_rd_data;

  bdl_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  bdl_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_rd_pop),
    .rd_data  (q_rd_data)
  );

  bdl_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .q_rd_valid      (q_rd_valid),
    .q_rd_pop        (q_rd_pop),
    .q_rd_data       (q_rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_in_run (out_last_in_run)
  );

endmodule

/* sim/binarize_dilate_2x2_unit_tb.sv */
// ----------------------------------------------------------------------------
// binarize_dilate_2x2_unit_tb
// Drives raster pixel streams through the binarize / 2x2 dilation unit and
// checks every emitted pixel, its row, its column and the end-of-run flag
// against an in-bench line-buffer predictor. Runs directed cases first,
// then random frames of many shapes, under changing handshake pressure.
// ----------------------------------------------------------------------------
module binarize_dilate_2x2_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdl_pkg::*;

  localparam int MAXW          = MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } dil_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_reg_t              cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic                  out_last_in_run;

  // predictor state
  logic [PIX_W-1:0]  thr_reg    = THRESH_RESET;
  logic [HGT_W-1:0]  height_reg = HEIGHT_RESET;
  logic [WID_W-1:0]  width_reg  = WIDTH_RESET;
  logic [2*MAXW-1:0] line_bits  = '0;
  logic              wr_bank    = 1'b0;
  int                row_pos    = 0;
  int                col_pos    = 0;

  dil_result_t dilated_q[$];
  int          mismatches    = 0;
  int          pixels_sent   = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  binarize_dilate_2x2_unit #(.MAX_WIDTH(MAXW)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_in_run (out_last_in_run)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic dil_result_t make_result(input logic on, input int r, input int c);
    dil_result_t res;
    res.pixel = on ? PIX_ON : PIX_OFF;
    res.row   = r[ROW_W-1:0];
    res.col   = c[OUT_COL_W-1:0];
    res.last  = 1'b0;
    return res;
  endfunction

  function automatic void predict_dilation(input logic [PIX_W-1:0] px);
    int          w, h, r, c, cur, prv;
    logic        b, v;
    dil_result_t res[$];
    b = (px >= thr_reg);
    w = eff_width();
    h = eff_height();
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    cur = wr_bank ? MAXW : 0;
    prv = wr_bank ? 0 : MAXW;
    line_bits[cur + c] = b;
    if (r >= 1) begin
      if (c >= 1) begin
        v = line_bits[prv + c - 1] | line_bits[prv + c] | line_bits[cur + c - 1] | b;
        res.push_back(make_result(v, r - 1, c - 1));
      end
      if (c == w - 1) res.push_back(make_result(line_bits[prv + c], r - 1, c));
    end
    if (c == w - 1) begin
      col_pos = 0;
      wr_bank = ~wr_bank;
      if (r == h - 1) begin
        // end of frame: last row goes out as-is
        for (int k = 0; k < w; k++) res.push_back(make_result(line_bits[cur + k], r, k));
        row_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) dilated_q.push_back(res[i]);
  endfunction

  always @(posedge clk) begin
    dil_result_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (dilated_q.size() == 0) begin
        $error("unexpected result: pixel %0d row %0d col %0d", out_pixel, out_row, out_col);
        mismatches++;
      end else begin
        exp_px = dilated_q.pop_front();
        if (out_pixel !== exp_px.pixel) begin
          $error("out_pixel: expected %0d, got %0d", exp_px.pixel, out_pixel);
          mismatches++;
        end
        if (out_row !== exp_px.row) begin
          $error("out_row: expected %0d, got %0d", exp_px.row, out_row);
          mismatches++;
        end
        if (out_col !== exp_px.col) begin
          $error("out_col: expected %0d, got %0d", exp_px.col, out_col);
          mismatches++;
        end
        if (out_last_in_run !== exp_px.last) begin
          $error("out_last_in_run: expected %0d, got %0d", exp_px.last, out_last_in_run);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    predict_dilation(px);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:    thr_reg    = val[PIX_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = val;
      CFG_FRAME_WIDTH:  width_reg  = val[WID_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] next_pixel();
    int t;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? PIX_ON : PIX_OFF;
      1: begin
        t = int'(thr_reg) + $urandom_range(0, 2) - 1;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[PIX_W-1:0];
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // register shrinks while mid-row / mid-frame push the counters past the end
  task automatic test_counter_clamp();
    send_pixel(8'd0);
    send_pixel(8'd127);
    send_pixel(8'd126);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    send_pixel(8'd255);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    send_pixel(8'd200);
    send_pixel(8'd10);
    send_pixel(8'd10);
    send_pixel(8'd10);
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    send_pixel(8'd10);
    send_pixel(8'd130);
    wait_idle();
  endtask

  // zero width and height act as one; threshold at both ends
  task automatic test_degenerate_frame();
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    write_reg(CFG_THRESHOLD, 13'd255);
    send_pixel(8'd254);
    send_pixel(8'd255);
    wait_idle();
    write_reg(CFG_THRESHOLD, 13'd0);
    send_pixel(8'd0);
    wait_idle();
  endtask

  // single lit pixel in a 3x3 frame, plus one on the last row and column
  task automatic test_dilation_pattern();
    write_reg(CFG_THRESHOLD, 13'd128);
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    send_pixel(8'd127);
    send_pixel(8'd127);
    send_pixel(8'd127);
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd127);
    send_pixel(8'd200);
    wait_idle();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct, input int n_pixels);
    int start, w, h, planned;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = pixels_sent;
    while (pixels_sent - start < n_pixels) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: write_reg(CFG_THRESHOLD, 13'd0);
        1: write_reg(CFG_THRESHOLD, 13'd255);
        default: write_reg(CFG_THRESHOLD, 13'($urandom_range(0, 255)));
      endcase
      case ($urandom_range(0, 11))
        0: write_reg(CFG_FRAME_HEIGHT, 13'd0);
        1: write_reg(CFG_FRAME_HEIGHT, MAX_HEIGHT);
        2: write_reg(CFG_FRAME_HEIGHT, 13'd8191);
        3: write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(4097, 8191)));
        default: write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(1, 5)));
      endcase
      case ($urandom_range(0, 11))
        0: write_reg(CFG_FRAME_WIDTH, 13'd0);
        1: write_reg(CFG_FRAME_WIDTH, 13'd32);
        2: write_reg(CFG_FRAME_WIDTH, 13'd63);
        3: write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(33, 63)));
        default: write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(1, 8)));
      endcase
      w = eff_width();
      h = eff_height();
      planned = w * h * $urandom_range(1, 2);
      if (planned > 70) planned = w * $urandom_range(2, 70 / w);
      if ($urandom_range(0, 1)) planned += $urandom_range(0, w - 1);
      for (int i = 0; i < planned; i++) send_pixel(next_pixel());
      // close an open frame by shrinking the height to the current row
      if (row_pos != 0 || col_pos != 0) begin
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 13'(row_pos + 1));
        planned = w - col_pos;
        for (int i = 0; i < planned; i++) send_pixel(next_pixel());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 78;
    test_counter_clamp();
    test_degenerate_frame();
    test_dilation_pattern();
    test_random_frames(38, 78, 70);
    test_random_frames(78, 38, 70);
    test_random_frames(0, 0, 70);

    if (mismatches == 0 && dilated_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
